[src/fresnel_dielectric_reflectance_macros.svh]
// ----------------------------------------------------------------------------
// Fresnel reflectance assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FDR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fresnel reflectance assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fresnel reflectance assertion failed");

`endif

[src/fdr_pkg.sv]
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Transaction types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package fdr_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } ray_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
    logic        from_inside;
  } refl_t;

  typedef struct packed {
    logic [16:0] ci;
    logic [13:0] ei;
    logic [13:0] et;
    logic        hit_inside;
    logic        tir;
  } side_t;

  localparam logic        CFG_INDEX_INSIDE  = 1'b0;
  localparam logic        CFG_INDEX_OUTSIDE = 1'b1;
  localparam logic [13:0] INDEX_RESET       = 14'd4096;

endpackage

[src/fdr_div_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; numerator bits shift out as quotient bits enter.
// ----------------------------------------------------------------------------
module fdr_div_pipe #(
  parameter int DEN_W  = 32,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [Q_W-1:0]    in_bits,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    qb_q   [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic              vld_q  [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W-1:0]  p_rem;
    logic [Q_W-1:0]    p_qb;
    logic [DEN_W-1:0]  p_den;
    logic [SIDE_W-1:0] p_side;
    logic              p_vld;
    logic [DEN_W:0]    r2;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign p_rem  = in_rem;
      assign p_qb   = in_bits;
      assign p_den  = in_den;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_q[i-1];
      assign p_qb   = qb_q[i-1];
      assign p_den  = den_q[i-1];
      assign p_side = side_q[i-1];
      assign p_vld  = vld_q[i-1];
    end

    assign r2   = {p_rem, p_qb[Q_W-1]};
    assign diff = r2 - {1'b0, p_den};
    assign ge   = (r2 >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        qb_q[i]   <= {p_qb[Q_W-2:0], ge};
        den_q[i]  <= p_den;
        side_q[i] <= p_side;
      end
    end
  end

  assign out_valid = vld_q[Q_W-1];
  assign out_quo   = qb_q[Q_W-1];
  assign out_side  = side_q[Q_W-1];

endmodule

[src/fdr_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor of the square root of the input.
// ----------------------------------------------------------------------------
module fdr_sqrt_pipe #(
  parameter int RES_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*RES_W-2:0]   in_x,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [RES_W-1:0]     out_root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int W = 2 * RES_W;

  logic [W-1:0]      rem_q  [RES_W];
  logic [RES_W-1:0]  res_q  [RES_W];
  logic [SIDE_W-1:0] side_q [RES_W];
  logic              vld_q  [RES_W];

  for (genvar i = 0; i < RES_W; i++) begin : g_step
    localparam int K = RES_W - 1 - i;
    logic [W-1:0]      p_rem;
    logic [RES_W-1:0]  p_res;
    logic [SIDE_W-1:0] p_side;
    logic              p_vld;
    logic [W-1:0]      trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign p_rem  = W'(in_x);
      assign p_res  = '0;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_q[i-1];
      assign p_res  = res_q[i-1];
      assign p_side = side_q[i-1];
      assign p_vld  = vld_q[i-1];
    end

    assign trial = (W'(p_res) << (K + 1)) | (W'(1) << (2 * K));
    assign ge    = (p_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? p_rem - trial : p_rem;
        res_q[i]  <= ge ? (p_res | (RES_W'(1) << K)) : p_res;
        side_q[i] <= p_side;
      end
    end
  end

  assign out_valid = vld_q[RES_W-1];
  assign out_root  = res_q[RES_W-1];
  assign out_side  = side_q[RES_W-1];

endmodule

[src/fresnel_dielectric_reflectance.sv]
// ----------------------------------------------------------------------------
// Fresnel dielectric reflectance
// Unpolarized reflectance of a dielectric interface for a stream of ray hits.
// ----------------------------------------------------------------------------
//   Channel  Handshake             Payload
//   ray      ray_valid/ray_stall   fdr_pkg::ray_t (direction, normal)
//   refl     refl_valid/refl_stall fdr_pkg::refl_t (reflectance, flags)
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One transaction enters per cycle while the output is not stalled; the path
// runs through the pipelined divider (33 stages), square root (17 stages) and
// ratio dividers (31 stages). The whole pipeline holds while the output register
// is full and stalled. Reset clears all valid bits and loads both indices
// with 1.0.
// ----------------------------------------------------------------------------
`include "fresnel_dielectric_reflectance_macros.svh"

module fresnel_dielectric_reflectance (
  input  logic           clk,
  input  logic           rst,
  input  logic           ray_valid,
  output logic           ray_stall,
  input  fdr_pkg::ray_t  ray,
  output logic           refl_valid,
  input  logic           refl_stall,
  output fdr_pkg::refl_t refl,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [13:0]    cfg_data
);

  localparam int SIDE_W = $bits(fdr_pkg::side_t);
  localparam logic signed [33:0] ONE28_P = 34'sd268435456;
  localparam logic signed [33:0] ONE28_N = -34'sd268435456;

  logic        en;
  logic [13:0] index_inside;
  logic [13:0] index_outside;

  assign en        = !(refl_valid && refl_stall);
  assign ray_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_inside  <= fdr_pkg::INDEX_RESET;
      index_outside <= fdr_pkg::INDEX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fdr_pkg::CFG_INDEX_INSIDE:  index_inside  <= cfg_data;
        fdr_pkg::CFG_INDEX_OUTSIDE: index_outside <= cfg_data;
        default: ;
      endcase
    end
  end

  // Products of the dot product.
  logic               v1;
  logic signed [31:0] p0, p1, p2;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= ray_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= 32'(ray.dir_x) * 32'(ray.norm_x);
      p1 <= 32'(ray.dir_y) * 32'(ray.norm_y);
      p2 <= 32'(ray.dir_z) * 32'(ray.norm_z);
    end
  end

  // Cosine, clamp and side of the surface.
  logic               v2, inside2;
  logic [28:0]        mag2;
  logic signed [33:0] dot, cosv, cosc;

  assign dot  = 34'(p0) + 34'(p1) + 34'(p2);
  assign cosv = -dot;
  assign cosc = (cosv > ONE28_P) ? ONE28_P : ((cosv < ONE28_N) ? ONE28_N : cosv);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside2 <= cosc[33];
      mag2    <= cosc[33] ? 29'(-cosc) : cosc[28:0];
    end
  end

  // Rounded cosine and index selection.
  logic        v3, inside3;
  logic [16:0] ci3;
  logic [13:0] ei3, et3, ein, eout;
  logic [29:0] rnd;

  assign rnd  = {1'b0, mag2} + 30'd2048;
  assign ein  = (index_inside == 14'd0) ? 14'd1 : index_inside;
  assign eout = (index_outside == 14'd0) ? 14'd1 : index_outside;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside3 <= inside2;
      ci3     <= rnd[28:12];
      ei3     <= inside2 ? ein : eout;
      et3     <= inside2 ? eout : ein;
    end
  end

  // Squares.
  logic        v4, inside4;
  logic [16:0] ci4;
  logic [13:0] ei4, et4;
  logic [32:0] cisq4;
  logic [27:0] ei2_4, et2_4;
  logic [33:0] cisq_full;

  assign cisq_full = 34'(ci3) * 34'(ci3);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside4 <= inside3;
      ci4     <= ci3;
      ei4     <= ei3;
      et4     <= et3;
      cisq4   <= cisq_full[32:0];
      ei2_4   <= 28'(ei3) * 28'(ei3);
      et2_4   <= 28'(et3) * 28'(et3);
    end
  end

  // Squared sine scaled by the incident index.
  logic        v5, inside5;
  logic [16:0] ci5;
  logic [13:0] ei5, et5;
  logic [27:0] et2_5;
  logic [59:0] lhs5, s2prod;
  logic [32:0] s2;

  assign s2     = 33'h1_0000_0000 - cisq4;
  assign s2prod = 60'(s2[31:0]) * 60'(ei2_4);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside5 <= inside4;
      ci5     <= ci4;
      ei5     <= ei4;
      et5     <= et4;
      et2_5   <= et2_4;
      lhs5    <= s2[32] ? {ei2_4, 32'd0} : s2prod;
    end
  end

  // Total internal reflection test and divider operands.
  logic                v6;
  logic [59:0]         rhs, n6;
  logic                tir;
  logic [27:0]         drem6, dden6;
  logic [32:0]         dbits6;
  fdr_pkg::side_t      side6;

  assign rhs = {et2_5, 32'd0};
  assign tir = (lhs5 >= rhs);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  assign n6 = tir ? 60'd0 : rhs - lhs5;

  always_ff @(posedge clk) begin
    if (en) begin
      drem6  <= {1'b0, n6[59:33]};
      dbits6 <= n6[32:0];
      dden6  <= et2_5;
      side6  <= '{ci: ci5, ei: ei5, et: et5, hit_inside: inside5, tir: tir};
    end
  end

  // Squared transmitted cosine.
  logic              vd;
  logic [32:0]       ct2;
  logic [SIDE_W-1:0] sided;

  fdr_div_pipe #(.DEN_W(28), .Q_W(33), .SIDE_W(SIDE_W)) u_ct2_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_rem    (drem6),
    .in_bits   (dbits6),
    .in_den    (dden6),
    .in_side   (side6),
    .out_valid (vd),
    .out_quo   (ct2),
    .out_side  (sided)
  );

  // Transmitted cosine.
  logic              vs;
  logic [16:0]       ct;
  logic [SIDE_W-1:0] sides;
  fdr_pkg::side_t    sd;

  fdr_sqrt_pipe #(.RES_W(17), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vd),
    .in_x      (ct2),
    .in_side   (sided),
    .out_valid (vs),
    .out_root  (ct),
    .out_side  (sides)
  );

  assign sd = fdr_pkg::side_t'(sides);

  // Index and cosine products.
  logic        v7, inside7, tir7;
  logic [30:0] a7, b7, d7, e7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= vs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside7 <= sd.hit_inside;
      tir7    <= sd.tir;
      a7      <= 31'(sd.ei) * 31'(sd.ci);
      b7      <= 31'(sd.et) * 31'(ct);
      d7      <= 31'(sd.ei) * 31'(ct);
      e7      <= 31'(sd.et) * 31'(sd.ci);
    end
  end

  // Differences and sums for both polarizations. A zero product makes the
  // ratio exactly one, which the dividers cannot represent.
  logic        v8;
  logic [31:0] srem8, sden8, prem8, pden8;
  logic [2:0]  sside8;
  logic        pside8;
  logic [31:0] ssum, psum;

  assign ssum = 32'(a7) + 32'(b7);
  assign psum = 32'(d7) + 32'(e7);

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srem8  <= 32'((a7 >= b7) ? a7 - b7 : b7 - a7);
      prem8  <= 32'((d7 >= e7) ? d7 - e7 : e7 - d7);
      sden8  <= ssum;
      pden8  <= psum;
      sside8 <= {tir7, inside7, (a7 == 31'd0) || (b7 == 31'd0)};
      pside8 <= (d7 == 31'd0) || (e7 == 31'd0);
    end
  end

  logic        vrs, vrp;
  logic [30:0] rs, rp;
  logic [2:0]  srs;
  logic        srp;

  fdr_div_pipe #(.DEN_W(32), .Q_W(31), .SIDE_W(3)) u_rs_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_rem    (srem8),
    .in_bits   (31'd0),
    .in_den    (sden8),
    .in_side   (sside8),
    .out_valid (vrs),
    .out_quo   (rs),
    .out_side  (srs)
  );

  fdr_div_pipe #(.DEN_W(32), .Q_W(31), .SIDE_W(1)) u_rp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_rem    (prem8),
    .in_bits   (31'd0),
    .in_den    (pden8),
    .in_side   (pside8),
    .out_valid (vrp),
    .out_quo   (rp),
    .out_side  (srp)
  );

  // Squares of the two amplitude ratios.
  logic        v9, inside9, tir9;
  logic [63:0] sq_s9, sq_p9;
  logic [31:0] rsv, rpv;

  assign rsv = srs[0] ? 32'h8000_0000 : {1'b0, rs};
  assign rpv = srp ? 32'h8000_0000 : {1'b0, rp};

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= vrs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir9    <= srs[2];
      inside9 <= srs[1];
      sq_s9   <= 64'(rsv) * 64'(rsv);
      sq_p9   <= 64'(rpv) * 64'(rpv);
    end
  end

  // Average, round, saturate.
  logic [63:0] tot;
  logic [16:0] kr;

  assign tot = sq_s9 + sq_p9 + 64'h0000_4000_0000_0000;
  assign kr  = tot[63:47];

  always_ff @(posedge clk) begin
    if (rst) refl_valid <= 1'b0;
    else if (en) refl_valid <= v9;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refl.total_internal <= tir9;
      refl.from_inside    <= inside9;
      refl.reflectance    <= (tir9 || kr[16]) ? 16'hFFFF : kr[15:0];
    end
  end

  `FDR_ASSERT_SAME(a_stall_follows_output, refl_valid && refl_stall, ray_stall)
  `FDR_ASSERT_SAME(a_tir_full_scale, refl_valid && refl.total_internal,
                   refl.reflectance == 16'hFFFF)
  `FDR_ASSERT_NEXT(a_tir_zero_numerator, en && v5 && tir,
                   drem6 == 28'd0 && dbits6 == 33'd0 && side6.tir)
  `FDR_ASSERT_SAME(a_divider_lanes_aligned, vrs != vrp, 1'b0)

endmodule

[bench/tb_fresnel_dielectric_reflectance.sv]
// ----------------------------------------------------------------------------
// Fresnel reflectance testbench
// Drives ray transactions through the block under several index settings,
// predicts each reflectance in fixed point and compares every result in order.
// ----------------------------------------------------------------------------
module tb_fresnel_dielectric_reflectance;
  timeunit 1ns;
  timeprecision 1ps;

  class refl_scoreboard;
    fdr_pkg::refl_t pending[$];
    logic [13:0] idx_in = fdr_pkg::INDEX_RESET;
    logic [13:0] idx_out = fdr_pkg::INDEX_RESET;
    int errors = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
        if (x >= res + bt) begin
          x = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function automatic logic [63:0] fresnel_ratio(logic [63:0] p, logic [63:0] q);
      logic [63:0] diff;
      diff = (p >= q) ? p - q : q - p;
      if (p + q == 0) return 64'd1 << 31;
      return (diff << 31) / (p + q);
    endfunction

    function automatic fdr_pkg::refl_t predict(fdr_pkg::ray_t r);
      longint dot, cosv;
      logic [63:0] ein, eout, ei, et, mag, ci, s2, lhs, rhs, ct, rs, rp, kr;
      fdr_pkg::refl_t o;
      dot = longint'(r.dir_x) * r.norm_x + longint'(r.dir_y) * r.norm_y
          + longint'(r.dir_z) * r.norm_z;
      cosv = -dot;
      if (cosv > (64'sd1 <<< 28)) cosv = 64'sd1 <<< 28;
      if (cosv < -(64'sd1 <<< 28)) cosv = -(64'sd1 <<< 28);
      ein = (idx_in != 0) ? idx_in : 1;
      eout = (idx_out != 0) ? idx_out : 1;
      o.from_inside = cosv < 0;
      if (cosv < 0) begin
        ei = ein;
        et = eout;
        mag = -cosv;
      end else begin
        ei = eout;
        et = ein;
        mag = cosv;
      end
      ci = (mag + 2048) >> 12;
      s2 = (64'd1 << 32) - ci * ci;
      lhs = s2 * ei * ei;
      rhs = (et * et) << 32;
      if (lhs >= rhs) begin
        o.reflectance = 16'hFFFF;
        o.total_internal = 1'b1;
        return o;
      end
      ct = int_sqrt((rhs - lhs) / (et * et));
      rs = fresnel_ratio(ei * ci, et * ct);
      rp = fresnel_ratio(ei * ct, et * ci);
      kr = (rs * rs + rp * rp + (64'd1 << 46)) >> 47;
      o.reflectance = (kr > 65535) ? 16'hFFFF : kr[15:0];
      o.total_internal = 1'b0;
      return o;
    endfunction

    function void note_ray(fdr_pkg::ray_t r);
      pending.push_back(predict(r));
    endfunction

    function void check_refl(fdr_pkg::refl_t got);
      fdr_pkg::refl_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected reflectance transaction %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.reflectance !== exp_r.reflectance) begin
        $error("reflectance expected %0d actual %0d", exp_r.reflectance, got.reflectance);
        errors++;
      end
      if (got.total_internal !== exp_r.total_internal) begin
        $error("total_internal expected %0b actual %0b", exp_r.total_internal,
               got.total_internal);
        errors++;
      end
      if (got.from_inside !== exp_r.from_inside) begin
        $error("from_inside expected %0b actual %0b", exp_r.from_inside, got.from_inside);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic ray_valid, ray_stall, refl_valid, refl_stall;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [13:0] cfg_data;
  fdr_pkg::ray_t ray;
  fdr_pkg::refl_t refl;
  int send_idle, recv_idle;
  bit hold_recv;
  refl_scoreboard sb;

  fresnel_dielectric_reflectance uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (ray_valid && !ray_stall) sb.note_ray(ray);
      if (refl_valid && !refl_stall) sb.check_refl(refl);
    end
    refl_stall <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_ray(fdr_pkg::ray_t r);
    while ($urandom_range(99) < send_idle) begin
      ray_valid <= 1'b0;
      @(posedge clk);
    end
    ray_valid <= 1'b1;
    ray <= r;
    @(posedge clk);
    while (ray_stall) @(posedge clk);
  endtask

  task automatic send_random(int n);
    fdr_pkg::ray_t r;
    repeat (n) begin
      r.dir_x = rand_comp();
      r.dir_y = rand_comp();
      r.dir_z = rand_comp();
      if ($urandom_range(3) == 0) begin
        r.norm_x = r.dir_x;
        r.norm_y = r.dir_y;
        r.norm_z = r.dir_z;
      end else begin
        r.norm_x = rand_comp();
        r.norm_y = rand_comp();
        r.norm_z = rand_comp();
      end
      send_ray(r);
    end
    ray_valid <= 1'b0;
  endtask

  task automatic write_index(logic which, logic [13:0] value);
    ray_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (which == fdr_pkg::CFG_INDEX_INSIDE) sb.idx_in = value;
    else sb.idx_out = value;
  endtask

  initial begin
    fdr_pkg::ray_t r;
    logic [13:0] ins[6] = '{14'd6144, 14'd1, 14'd16383, 14'd0, 14'd5461, 14'd4096};
    logic [13:0] outs[6] = '{14'd4096, 14'd16383, 14'd1, 14'd4096, 14'd0, 14'd6144};
    sb = new();
    rst = 1; ray_valid = 0; ray = '0;
    cfg_valid = 0; cfg_index = fdr_pkg::CFG_INDEX_INSIDE; cfg_data = '0;
    hold_recv = 0; send_idle = 0; recv_idle = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_index(fdr_pkg::CFG_INDEX_INSIDE, 14'd6144);
    r = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384};
    send_ray(r);
    r = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384};
    send_ray(r);
    r = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_ray(r);
    r = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384};
    send_ray(r);
    r = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
    send_ray(r);
    r = '{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768};
    send_ray(r);
    r = '{16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_ray(r);
    ray_valid <= 1'b0;
    send_idle = 18; recv_idle = 48;
    send_random(20);
    fork
      send_random(300);
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
    join
    for (int k = 0; k < 6; k++) begin
      write_index(fdr_pkg::CFG_INDEX_INSIDE, ins[k]);
      write_index(fdr_pkg::CFG_INDEX_OUTSIDE, outs[k]);
      if (k == 2) begin
        send_idle = 48; recv_idle = 18;
      end else if (k == 4) begin
        send_idle = 0; recv_idle = 0;
      end
      send_random(150);
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/fdr_pkg.sv
src/fdr_div_pipe.sv
src/fdr_sqrt_pipe.sv
src/fresnel_dielectric_reflectance.sv
bench/tb_fresnel_dielectric_reflectance.sv
